// File: rtl/lwls_pkg.sv
// lwls_pkg: shared constants, codes and the command and status structs
// of the loss-weighted lottery scheduler
// no dependencies
package lwls_pkg;

   localparam int OP_W      = 1;
   localparam int QID_W     = 3;
   localparam int FRAC_W    = 16;
   localparam int BACKLOG_W = 19;
   localparam int CFG_W     = 4;
   localparam int CNT_W     = 32;

   localparam logic [BACKLOG_W-1:0] BACKLOG_MAX      = '1;
   localparam logic [CFG_W-1:0]     CFG_QUEUES_RESET = 4'd8;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 1'b0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic enq_check;
      logic div_take;
      logic mul;
      logic walk;
      logic write;
      logic deliver;
   } lwls_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic enq_refused;
      logic div_done;
      logic walk_done;
      logic walk_found;
      logic out_free;
   } lwls_status_type;

endpackage

// File: rtl/lwls_if.sv
// lwls_if: channel interfaces of the scheduler (request, response, csr write)
// depends on lwls_pkg for the field widths
interface lwls_req_if;
   import lwls_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [QID_W-1:0]  queue_id;
   logic              link_error;
   logic [FRAC_W-1:0] rand_frac;

   modport source (output valid, op, queue_id, link_error, rand_frac, input ready);
   modport sink   (input valid, op, queue_id, link_error, rand_frac, output ready);
endinterface

interface lwls_rsp_if;
   import lwls_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 granted;
   logic [QID_W-1:0]     granted_queue;
   logic                 refused;
   logic [BACKLOG_W-1:0] backlog;

   modport source (output valid, granted, granted_queue, refused, backlog, input ready);
   modport sink   (input valid, granted, granted_queue, refused, backlog, output ready);
endinterface

interface lwls_csr_if;
   import lwls_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/lwls_ram.sv
// lwls_ram: generic single write port, single read port ram, registered read
// no dependencies
module lwls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/lwls_divider.sv
// lwls_divider: restoring divider, one quotient bit a cycle
// computes floor(loss * 2^FRAC_BITS / divisor) for loss below divisor
// depends on lwls_pkg
module lwls_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lwls_pkg::CNT_W-1:0] loss_in,
   input  logic [lwls_pkg::CNT_W:0]   divisor_in,
   output logic                      done,
   output logic [FRAC_BITS-1:0]      quotient
);
   import lwls_pkg::*;

   localparam int CW = $clog2(FRAC_BITS + 1);

   logic [CNT_W:0]     rem_ff, rem_in;
   logic [CNT_W:0]     div_ff;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [CNT_W+1:0]   shifted;
   logic               ge;

   // remainder always stays below the divisor, so one bit of headroom is enough
   assign shifted = {rem_ff, 1'b0};
   assign ge      = shifted >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = {1'b0, loss_in};
         quo_in  = '0;
         cnt_in  = CW'(FRAC_BITS);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         rem_in = ge ? (CNT_W + 1)'(shifted - {1'b0, div_ff}) : (CNT_W + 1)'(shifted);
         quo_in = {quo_ff[FRAC_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff <= divisor_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: rtl/lwls_datapath.sv
// lwls_datapath: per-queue record ram, weight cache sums, lottery walk,
// weight divider and result register
// depends on lwls_pkg, lwls_ram and lwls_divider
module lwls_datapath #(
   parameter int NUM_QUEUES       = 8,
   parameter int WEIGHT_FRAC_BITS = 16,
   parameter int LENGTH_BITS      = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lwls_pkg::lwls_cmd_type       cmd,
   output lwls_pkg::lwls_status_type    status,
   input  logic [lwls_pkg::OP_W-1:0]    req_op,
   input  logic [lwls_pkg::QID_W-1:0]   req_queue_id,
   input  logic                         req_link_error,
   input  logic [lwls_pkg::FRAC_W-1:0]  req_rand_frac,
   input  logic                         csr_valid,
   input  logic [lwls_pkg::CFG_W-1:0]   csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_granted,
   output logic [lwls_pkg::QID_W-1:0]   rsp_granted_queue,
   output logic                         rsp_refused,
   output logic [lwls_pkg::BACKLOG_W-1:0] rsp_backlog
);
   import lwls_pkg::*;

   localparam int QW    = $clog2(NUM_QUEUES);
   localparam int WW    = WEIGHT_FRAC_BITS + 1;
   localparam int SW    = WEIGHT_FRAC_BITS + 1 + QW;
   localparam int BW    = LENGTH_BITS + QW;
   localparam int REC_W = LENGTH_BITS + WW + 2 * CNT_W;
   localparam int CMP_W = (QW + 1 > QID_W) ? QW + 1 : QID_W;
   localparam int NW    = (QW + 1 > CFG_W) ? QW + 1 : CFG_W;
   localparam int BX    = (BW > BACKLOG_W) ? BW : BACKLOG_W;
   localparam int PW    = FRAC_W + SW;
   localparam logic [WW-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   // captured request
   logic [OP_W-1:0]   op_ff;
   logic [QID_W-1:0]  qid_ff;
   logic              err_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic              in_range_ff;
   logic              in_range;

   // configuration
   logic [CFG_W-1:0]  queues_in_use_ff;
   logic [NW-1:0]     cfg_ext, n_eff;
   logic [QW-1:0]     last_idx;

   // record ram and entry valid bits
   logic [NUM_QUEUES-1:0] valid_ff;
   logic                  rdv_ff;
   logic                  rd_en;
   logic [QW-1:0]         rd_addr;
   logic [REC_W-1:0]      rd_data, rd_rec, wr_data;
   logic [LENGTH_BITS-1:0] rd_len;
   logic [WW-1:0]          rd_w;
   logic [CNT_W-1:0]       rd_loss, rd_arr;

   // record under update
   logic [LENGTH_BITS-1:0] work_len_ff;
   logic [WW-1:0]          work_w_ff, old_w_ff;
   logic [CNT_W-1:0]       work_loss_ff, work_arr_ff;
   logic [QW-1:0]          target_ff;

   // enqueue arithmetic
   logic                   enq_refused;
   logic                   arr_sat;
   logic [CNT_W-1:0]       new_arr, new_loss;
   logic                   div_start, div_done;
   logic [WEIGHT_FRAC_BITS-1:0] div_quo;

   // lottery walk
   logic [SW-1:0]  sum_ff, thr_ff, cum_ff, cum_next;
   logic [PW-1:0]  prod;
   logic [QW-1:0]  eval_idx_ff;
   logic           cand_valid_ff;
   logic           cur_nonempty, hit, walk_last;

   // totals and result
   logic [BW-1:0]        backlog_ff;
   logic [BX-1:0]        bl_ext;
   logic [BACKLOG_W-1:0] bl_sat;
   logic                 res_granted_ff, res_refused_ff;
   logic                 out_valid_ff;
   logic                 out_granted_ff, out_refused_ff;
   logic [QID_W-1:0]     out_queue_ff;
   logic [BACKLOG_W-1:0] out_backlog_ff;

   assign in_range = CMP_W'(req_queue_id) < CMP_W'(NUM_QUEUES);

   // queues_in_use of zero acts as one, above the queue count as the queue count
   assign cfg_ext  = NW'(queues_in_use_ff);
   assign n_eff    = (cfg_ext == '0) ? NW'(1) :
                     (cfg_ext > NW'(NUM_QUEUES)) ? NW'(NUM_QUEUES) : cfg_ext;
   assign last_idx = QW'(n_eff - NW'(1));

   assign rd_rec  = rdv_ff ? rd_data : '0;
   assign rd_arr  = rd_rec[CNT_W-1:0];
   assign rd_loss = rd_rec[2*CNT_W-1:CNT_W];
   assign rd_w    = rd_rec[2*CNT_W+WW-1:2*CNT_W];
   assign rd_len  = rd_rec[REC_W-1:2*CNT_W+WW];
   assign wr_data = {work_len_ff, work_w_ff, work_loss_ff, work_arr_ff};

   assign enq_refused = !in_range_ff || (&rd_len);
   assign arr_sat     = &rd_arr;
   assign new_arr     = arr_sat ? rd_arr : rd_arr + 1'b1;
   assign new_loss    = (!arr_sat && err_ff && !(&rd_loss)) ? rd_loss + 1'b1 : rd_loss;
   assign div_start   = cmd.enq_check && !enq_refused;

   assign prod         = PW'(frac_ff) * PW'(sum_ff);
   assign cur_nonempty = rd_len != '0;
   assign cum_next     = cum_ff + (cur_nonempty ? SW'(rd_w) : SW'(0));
   assign hit          = cur_nonempty && (cum_next > thr_ff);
   assign walk_last    = eval_idx_ff == last_idx;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.accept) begin
         rd_en   = (req_op == OP_DEQUEUE) || in_range;
         rd_addr = (req_op == OP_DEQUEUE) ? QW'(0) : QW'(req_queue_id);
      end else if (cmd.walk) begin
         rd_en   = !walk_last;
         rd_addr = eval_idx_ff + 1'b1;
      end
   end

   lwls_ram #(
      .WIDTH (REC_W),
      .DEPTH (NUM_QUEUES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (target_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lwls_divider #(
      .FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .loss_in    (new_loss),
      .divisor_in ({1'b0, new_arr} + 1'b1),
      .done       (div_done),
      .quotient   (div_quo)
   );

   assign bl_ext = BX'(backlog_ff);
   assign bl_sat = (bl_ext > BX'(BACKLOG_MAX)) ? BACKLOG_MAX : bl_ext[BACKLOG_W-1:0];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         queues_in_use_ff <= CFG_QUEUES_RESET;
         valid_ff         <= '0;
         rdv_ff           <= 1'b0;
         sum_ff           <= '0;
         backlog_ff       <= '0;
         cand_valid_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            queues_in_use_ff <= csr_data;
         end
         if (rd_en) begin
            rdv_ff <= valid_ff[rd_addr];
         end
         if (cmd.accept) begin
            cand_valid_ff <= 1'b0;
         end else if (cmd.walk && cur_nonempty) begin
            cand_valid_ff <= 1'b1;
         end
         if (cmd.write) begin
            valid_ff[target_ff] <= 1'b1;
            sum_ff <= sum_ff - SW'(old_w_ff) + SW'(work_w_ff);
            if (op_ff == OP_DEQUEUE) begin
               backlog_ff <= backlog_ff - 1'b1;
            end else begin
               backlog_ff <= backlog_ff + 1'b1;
            end
         end
         if (cmd.deliver) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff          <= req_op;
         qid_ff         <= req_queue_id;
         err_ff         <= req_link_error;
         frac_ff        <= req_rand_frac;
         in_range_ff    <= in_range;
         res_granted_ff <= 1'b0;
         res_refused_ff <= 1'b0;
         cum_ff         <= '0;
         eval_idx_ff    <= '0;
      end
      if (cmd.enq_check) begin
         res_refused_ff <= enq_refused;
         work_len_ff    <= rd_len + 1'b1;
         work_w_ff      <= rd_w;
         work_loss_ff   <= new_loss;
         work_arr_ff    <= new_arr;
         old_w_ff       <= rd_w;
         target_ff      <= QW'(qid_ff);
      end
      if (cmd.div_take) begin
         work_w_ff <= WEIGHT_ONE - WW'(div_quo);
      end
      if (cmd.mul) begin
         thr_ff <= prod[PW-1:FRAC_W];
      end
      if (cmd.walk) begin
         cum_ff <= cum_next;
         if (!walk_last) begin
            eval_idx_ff <= eval_idx_ff + 1'b1;
         end
         // remember the latest non-empty queue, the fallback when rounding finds none
         if (cur_nonempty) begin
            work_len_ff  <= rd_len - 1'b1;
            work_w_ff    <= (rd_len == LENGTH_BITS'(1)) ? WW'(0) : rd_w;
            work_loss_ff <= rd_loss;
            work_arr_ff  <= rd_arr;
            old_w_ff     <= rd_w;
            target_ff    <= eval_idx_ff;
         end
      end
      if (cmd.write) begin
         res_granted_ff <= op_ff == OP_DEQUEUE;
      end
      if (cmd.deliver) begin
         out_granted_ff <= res_granted_ff;
         out_refused_ff <= res_refused_ff;
         out_queue_ff   <= res_granted_ff ? QID_W'(target_ff) : QID_W'(0);
         out_backlog_ff <= bl_sat;
      end
   end

   assign status.enq_refused = enq_refused;
   assign status.div_done    = div_done;
   assign status.walk_done   = hit || walk_last;
   assign status.walk_found  = cand_valid_ff || cur_nonempty;
   assign status.out_free    = !out_valid_ff || rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_granted       = out_granted_ff;
   assign rsp_granted_queue = out_queue_ff;
   assign rsp_refused       = out_refused_ff;
   assign rsp_backlog       = out_backlog_ff;

   a_enq_weight_range: assert property (@(posedge clock) disable iff (reset)
      cmd.write && (op_ff == OP_ENQUEUE) |-> (work_w_ff != '0) && (work_w_ff <= WEIGHT_ONE))
      else $error("enqueue writes a weight outside one lsb to one");

   a_deq_has_candidate: assert property (@(posedge clock) disable iff (reset)
      cmd.write && (op_ff == OP_DEQUEUE) |-> cand_valid_ff && (backlog_ff != '0))
      else $error("dequeue update without a served queue");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> sum_ff <= SW'(NUM_QUEUES) * SW'(WEIGHT_ONE))
      else $error("weight sum beyond all queues at full weight");

   a_grant_excludes_refuse: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |=> !(out_granted_ff && out_refused_ff))
      else $error("beat both granted and refused");
endmodule

// File: rtl/lwls_ctrl.sv
// lwls_ctrl: sequencing state machine of the scheduler
// depends on lwls_pkg
module lwls_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [lwls_pkg::OP_W-1:0] req_op,
   output logic                      req_ready,
   input  lwls_pkg::lwls_status_type status,
   output lwls_pkg::lwls_cmd_type    cmd
);
   import lwls_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_ENQ_CHECK = 7'b0000010,
      ST_ENQ_DIV   = 7'b0000100,
      ST_DEQ_MUL   = 7'b0001000,
      ST_DEQ_WALK  = 7'b0010000,
      ST_WRITE     = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_op == OP_DEQUEUE) ? ST_DEQ_MUL : ST_ENQ_CHECK;
            end
         end
         ST_ENQ_CHECK: begin
            cmd.enq_check = 1'b1;
            state_in      = status.enq_refused ? ST_DONE : ST_ENQ_DIV;
         end
         ST_ENQ_DIV: begin
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_WRITE;
            end
         end
         ST_DEQ_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DEQ_WALK;
         end
         ST_DEQ_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = status.walk_found ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: rtl/loss_weighted_lottery_scheduler.sv
// loss_weighted_lottery_scheduler: top level, joins controller and datapath
// depends on lwls_pkg, lwls_if, lwls_ctrl and lwls_datapath
//
// Keeps a packet, loss and arrival count per queue and serves queues by a
// weighted lottery, each queue weighted 1 - loss/(arrivals+1). One request
// beat is worked at a time and gives one response beat. An enqueue waits
// on the weight divider, which makes one quotient bit a cycle; a refused
// enqueue skips the divider. A dequeue's lottery walk reads the queues from
// the record ram in order until a winner is known, at most the effective
// queues_in_use of them. A finished response waits in its own register, so
// the next request is taken while it is unread. Configuration writes are
// always ready; counts and weights clear at reset.
module loss_weighted_lottery_scheduler #(
   parameter int NUM_QUEUES       = 8,
   parameter int WEIGHT_FRAC_BITS = 16,
   parameter int LENGTH_BITS      = 16
) (
   input  logic        clock,
   input  logic        reset,
   lwls_req_if.sink    req_chan,
   lwls_rsp_if.source  rsp_chan,
   lwls_csr_if.sink    csr_chan
);
   import lwls_pkg::*;

   lwls_cmd_type    cmd;
   lwls_status_type status;

   assign csr_chan.ready = 1'b1;

   lwls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lwls_datapath #(
      .NUM_QUEUES       (NUM_QUEUES),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
      .LENGTH_BITS      (LENGTH_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_chan.op),
      .req_queue_id      (req_chan.queue_id),
      .req_link_error    (req_chan.link_error),
      .req_rand_frac     (req_chan.rand_frac),
      .csr_valid         (csr_chan.valid),
      .csr_data          (csr_chan.data),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_granted       (rsp_chan.granted),
      .rsp_granted_queue (rsp_chan.granted_queue),
      .rsp_refused       (rsp_chan.refused),
      .rsp_backlog       (rsp_chan.backlog)
   );
endmodule
